>>> rtl/ihrc_pkg.sv
// ----------------------------------------------------------------------------
// ihrc_pkg: shared types and constants for the IPv4 header receive check
// Widths, register indexes, reset addresses and verdict codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ihrc_pkg;

    localparam int HEADER_WORDS = 10;
    localparam int POS_W        = $clog2(HEADER_WORDS);
    localparam int WORD_W       = 16;
    localparam int SUM_W        = 20;
    localparam int ADDR_W       = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [POS_W-1:0] FIRST_POS = '0;
    localparam logic [POS_W-1:0] TTL_POS   = POS_W'(4);
    localparam logic [POS_W-1:0] DEST_POS  = POS_W'(8);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(HEADER_WORDS - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = CFG_IDX_W'(1);

    localparam logic [ADDR_W-1:0] LOCAL_ADDR_RESET = 32'hC0A8_D68A;
    localparam logic [ADDR_W-1:0] BCAST_ADDR_RESET = 32'hFFFF_FFFF;

    localparam logic [3:0]        VERSION_IPV4 = 4'd4;
    localparam logic [3:0]        MIN_IHL      = 4'd5;
    localparam logic [WORD_W-1:0] CSUM_GOOD    = 16'hFFFF;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_VERSION  = 3'd1,
        VERDICT_HDR_LEN  = 3'd2,
        VERDICT_TTL      = 3'd3,
        VERDICT_DEST     = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } t_verdict;

    // Header fields captured while the words of one header arrive
    typedef struct packed {
        logic [3:0]        version;
        logic [3:0]        hdr_len;
        logic [7:0]        ttl;
        logic [WORD_W-1:0] dest_high;
        logic [SUM_W-1:0]  sum;
    } t_hdr_fields;

    typedef struct packed {
        t_verdict verdict;
        logic     accepted;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ihrc_ifs.sv
// ----------------------------------------------------------------------------
// ihrc interfaces: header word, result and configuration write channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihrc_hdr_if;
    logic                        valid;
    logic                        ready;
    logic [ihrc_pkg::WORD_W-1:0] header_word;
    logic                        start_of_header;

    modport source (output valid, header_word, start_of_header, input ready);
    modport sink   (input valid, header_word, start_of_header, output ready);
endinterface

interface ihrc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       accepted;

    modport source (output valid, verdict, accepted, input ready);
    modport sink   (input valid, verdict, accepted, output ready);
endinterface

interface ihrc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ihrc_pkg::CFG_IDX_W-1:0] index;
    logic [ihrc_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/ipv4_header_receive_check.sv
// ----------------------------------------------------------------------------
// ipv4_header_receive_check: per-header IPv4 validation, one word per beat
// Takes a header word per cycle unless stalled; the verdict is registered on the
// tenth word's beat. Input stalls only while two verdicts wait.
// Synchronous active-low reset clears position, fields and result buffer, and
// loads the default local and broadcast addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_receive_check (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ihrc_hdr_if.sink    i_hdr,
    ihrc_cfg_if.sink    i_cfg,
    ihrc_res_if.source  o_res
);

    // ------------------------------------------------------------------
    // Word tracking state
    // ------------------------------------------------------------------
    logic [ihrc_pkg::POS_W-1:0]  r_word_pos,  n_word_pos;
    ihrc_pkg::t_hdr_fields       r_fields,    n_fields;

    // Address registers, written from the configuration channel
    logic [ihrc_pkg::ADDR_W-1:0] r_local_addr;
    logic [ihrc_pkg::ADDR_W-1:0] r_bcast_addr;

    // Result buffer: output register plus one skid entry
    logic                        r_out_valid;
    ihrc_pkg::t_result           r_out;
    logic                        r_skid_valid;
    ihrc_pkg::t_result           r_skid;

    logic                        in_fire;
    logic                        out_fire;
    logic                        produce;
    logic [ihrc_pkg::POS_W-1:0]  pos;
    ihrc_pkg::t_result           new_result;

    // Hold the input whenever the skid entry is occupied; otherwise a
    // result beat always has a place to land.
    assign i_hdr.ready = !r_skid_valid;
    assign in_fire     = i_hdr.valid && i_hdr.ready;
    assign out_fire    = r_out_valid && o_res.ready;

    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Next-state for the header being collected
    // ------------------------------------------------------------------
    always_comb begin
        // A start mark restarts the count; the partial header is dropped.
        pos      = i_hdr.start_of_header ? ihrc_pkg::FIRST_POS : r_word_pos;
        n_fields = r_fields;

        if (pos == ihrc_pkg::FIRST_POS) begin
            n_fields.sum     = ihrc_pkg::SUM_W'(i_hdr.header_word);
            n_fields.version = i_hdr.header_word[15:12];
            n_fields.hdr_len = i_hdr.header_word[11:8];
        end else begin
            n_fields.sum = r_fields.sum + ihrc_pkg::SUM_W'(i_hdr.header_word);
        end

        if (pos == ihrc_pkg::TTL_POS) begin
            n_fields.ttl = i_hdr.header_word[15:8];
        end
        if (pos == ihrc_pkg::DEST_POS) begin
            n_fields.dest_high = i_hdr.header_word;
        end

        // Wrap to word zero after the last word so headers can run back to back.
        if (pos == ihrc_pkg::LAST_POS) begin
            n_word_pos = ihrc_pkg::FIRST_POS;
        end else begin
            n_word_pos = pos + ihrc_pkg::POS_W'(1);
        end

        produce = in_fire && (pos == ihrc_pkg::LAST_POS);
    end

    // The last word is the low half of the destination and joins the sum
    // in n_fields, so the verdict sees the complete header in this beat.
    ihrc_verdict u_verdict (
        .i_fields     (n_fields),
        .i_dest_low   (i_hdr.header_word),
        .i_local_addr (r_local_addr),
        .i_bcast_addr (r_bcast_addr),
        .o_result     (new_result)
    );

    // ------------------------------------------------------------------
    // Header state and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos   <= ihrc_pkg::FIRST_POS;
            r_fields     <= '0;
            r_local_addr <= ihrc_pkg::LOCAL_ADDR_RESET;
            r_bcast_addr <= ihrc_pkg::BCAST_ADDR_RESET;
        end else begin
            if (in_fire) begin
                r_word_pos <= n_word_pos;
                r_fields   <= n_fields;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    ihrc_pkg::CFG_LOCAL_ADDR: r_local_addr <= i_cfg.data;
                    ihrc_pkg::CFG_BCAST_ADDR: r_bcast_addr <= i_cfg.data;
                    default: ; // drop writes to unmapped indexes
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // A result lands in the output register when it is free or draining,
    // and in the skid entry when the output is stalled. The skid entry
    // advances into the output register as soon as the output drains.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= produce;
                end
            end else if (produce) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (produce) begin
                r_out <= new_result;
            end
        end else if (produce) begin
            r_skid <= new_result;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.verdict  = r_out.verdict;
    assign o_res.accepted = r_out.accepted;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_pos <= ihrc_pkg::LAST_POS)
        else $error("word position ran past the last header word");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> r_out_valid)
        else $error("verdict for a complete header was lost");

    a_accept_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.accepted == (r_out.verdict == ihrc_pkg::VERDICT_OK)))
        else $error("accepted flag disagrees with verdict");
`endif

endmodule

`default_nettype wire

>>> rtl/ihrc_verdict.sv
// ----------------------------------------------------------------------------
// ihrc_verdict: verdict for one complete header
// Folds the word sum and applies the checks in priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module ihrc_verdict (
    input  wire ihrc_pkg::t_hdr_fields          i_fields,
    input  wire logic [ihrc_pkg::WORD_W-1:0]    i_dest_low,
    input  wire logic [ihrc_pkg::ADDR_W-1:0]    i_local_addr,
    input  wire logic [ihrc_pkg::ADDR_W-1:0]    i_bcast_addr,
    output ihrc_pkg::t_result                   o_result
);

    logic [ihrc_pkg::WORD_W:0]    fold1;
    logic [ihrc_pkg::WORD_W-1:0]  fold2;
    logic [ihrc_pkg::ADDR_W-1:0]  dest;
    ihrc_pkg::t_verdict           verdict;

    // Two folds always clear the carry: the first leaves at most 0x1000E.
    always_comb begin
        fold1 = {1'b0, i_fields.sum[ihrc_pkg::WORD_W-1:0]}
              + (ihrc_pkg::WORD_W+1)'(i_fields.sum[ihrc_pkg::SUM_W-1:ihrc_pkg::WORD_W]);
        fold2 = fold1[ihrc_pkg::WORD_W-1:0]
              + ihrc_pkg::WORD_W'(fold1[ihrc_pkg::WORD_W]);
        dest  = {i_fields.dest_high, i_dest_low};

        if (i_fields.version != ihrc_pkg::VERSION_IPV4) begin
            verdict = ihrc_pkg::VERDICT_VERSION;
        end else if (i_fields.hdr_len < ihrc_pkg::MIN_IHL) begin
            verdict = ihrc_pkg::VERDICT_HDR_LEN;
        end else if (i_fields.ttl == 8'd0) begin
            verdict = ihrc_pkg::VERDICT_TTL;
        end else if (dest != i_local_addr && dest != i_bcast_addr) begin
            verdict = ihrc_pkg::VERDICT_DEST;
        end else if (fold2 != ihrc_pkg::CSUM_GOOD) begin
            verdict = ihrc_pkg::VERDICT_CHECKSUM;
        end else begin
            verdict = ihrc_pkg::VERDICT_OK;
        end

        o_result.verdict  = verdict;
        o_result.accepted = (verdict == ihrc_pkg::VERDICT_OK);
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the IPv4 header receive check
// Streams header words into the block: well-formed headers with one chosen
// fault, unmarked back-to-back headers, abandoned headers and stray words.
// Both channels idle and stall at random. A scoreboard predicts each verdict
// and checks the result beats in order, across several address settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int TOTAL_WORDS   = 1950;
    localparam int DIRECTED_WORDS = 24;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_WORDS   = (TOTAL_WORDS - DIRECTED_WORDS) / NUM_PHASES;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 3000;

    // Fault planted in a generated header; FAULT_NONE plants no fault
    typedef enum int {
        FAULT_NONE,
        FAULT_VERSION,
        FAULT_HDR_LEN,
        FAULT_TTL,
        FAULT_DEST,
        FAULT_CHECKSUM
    } t_fault;

    // Scoreboard: tracks the header in progress word by word and queues
    // the verdict each completed header must produce.
    class ihrc_verdict_board;
        logic [ihrc_pkg::ADDR_W-1:0] host_addr;
        logic [ihrc_pkg::ADDR_W-1:0] bcast_addr;
        logic [ihrc_pkg::POS_W-1:0]  word_pos;
        ihrc_pkg::t_hdr_fields       fields;
        ihrc_pkg::t_result           pending_verdicts[$];
        int                          mismatches;
        int                          words_seen;
        int                          verdict_hits[6];

        function new();
            host_addr  = ihrc_pkg::LOCAL_ADDR_RESET;
            bcast_addr = ihrc_pkg::BCAST_ADDR_RESET;
            word_pos   = ihrc_pkg::FIRST_POS;
            fields     = '0;
            mismatches = 0;
            words_seen = 0;
            foreach (verdict_hits[i]) verdict_hits[i] = 0;
        endfunction

        function void set_register(logic [ihrc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ihrc_pkg::ADDR_W-1:0] value);
            if (idx == ihrc_pkg::CFG_LOCAL_ADDR)
                host_addr = value;
            else if (idx == ihrc_pkg::CFG_BCAST_ADDR)
                bcast_addr = value;
        endfunction

        // End-around carry: fold the bits above 16 back in until none remain
        function logic [ihrc_pkg::WORD_W-1:0] fold_sum(logic [ihrc_pkg::SUM_W-1:0] raw);
            logic [ihrc_pkg::SUM_W-1:0] acc;
            acc = raw;
            while (acc[ihrc_pkg::SUM_W-1:ihrc_pkg::WORD_W] != '0)
                acc = ihrc_pkg::SUM_W'(acc[ihrc_pkg::SUM_W-1:ihrc_pkg::WORD_W])
                    + ihrc_pkg::SUM_W'(acc[ihrc_pkg::WORD_W-1:0]);
            return acc[ihrc_pkg::WORD_W-1:0];
        endfunction

        function void note_word(logic [ihrc_pkg::WORD_W-1:0] w, logic sof);
            logic [ihrc_pkg::POS_W-1:0]  pos;
            logic [ihrc_pkg::ADDR_W-1:0] dest;
            ihrc_pkg::t_result           r;
            words_seen++;
            // a start mark drops whatever header is in progress
            if (sof)
                word_pos = ihrc_pkg::FIRST_POS;
            pos = word_pos;
            if (pos == ihrc_pkg::FIRST_POS) begin
                fields.sum     = ihrc_pkg::SUM_W'(w);
                fields.version = w[15:12];
                fields.hdr_len = w[11:8];
            end else begin
                fields.sum = fields.sum + ihrc_pkg::SUM_W'(w);
                if (pos == ihrc_pkg::TTL_POS)
                    fields.ttl = w[15:8];
                else if (pos == ihrc_pkg::DEST_POS)
                    fields.dest_high = w;
            end
            if (pos != ihrc_pkg::LAST_POS) begin
                word_pos = pos + 1'b1;
                return;
            end
            word_pos = ihrc_pkg::FIRST_POS;
            dest     = {fields.dest_high, w};
            if (fields.version != ihrc_pkg::VERSION_IPV4)
                r.verdict = ihrc_pkg::VERDICT_VERSION;
            else if (fields.hdr_len < ihrc_pkg::MIN_IHL)
                r.verdict = ihrc_pkg::VERDICT_HDR_LEN;
            else if (fields.ttl == '0)
                r.verdict = ihrc_pkg::VERDICT_TTL;
            else if (dest != host_addr && dest != bcast_addr)
                r.verdict = ihrc_pkg::VERDICT_DEST;
            else if (fold_sum(fields.sum) != ihrc_pkg::CSUM_GOOD)
                r.verdict = ihrc_pkg::VERDICT_CHECKSUM;
            else
                r.verdict = ihrc_pkg::VERDICT_OK;
            r.accepted = (r.verdict == ihrc_pkg::VERDICT_OK);
            pending_verdicts.push_back(r);
        endfunction

        function void check_verdict(logic [2:0] verdict, logic accepted);
            ihrc_pkg::t_result exp_r;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: expected none, got %0d/%0b",
                         $time, verdict, accepted);
                return;
            end
            exp_r = pending_verdicts.pop_front();
            verdict_hits[int'(exp_r.verdict)]++;
            if (verdict !== exp_r.verdict) begin
                mismatches++;
                $display("%0t: verdict mismatch: expected %0d (%s), got %0d",
                         $time, exp_r.verdict, exp_r.verdict.name(), verdict);
            end
            if (accepted !== exp_r.accepted) begin
                mismatches++;
                $display("%0t: accepted mismatch: expected %0b, got %0b",
                         $time, exp_r.accepted, accepted);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ihrc_hdr_if hdr_ch ();
    ihrc_res_if res_ch ();
    ihrc_cfg_if cfg_ch ();

    ipv4_header_receive_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    ihrc_verdict_board board = new();

    int src_idle_pct;   // chance in percent of a gap before a header word
    int sink_idle_pct;  // chance in percent per cycle of a result stall
    bit hold_req;       // ask the result side for one long hold-off
    int words_sent;
    int cfg_writes;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap lengths: mostly short, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Weight passing headers, spread the rest over every fault
    function automatic t_fault pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return FAULT_NONE;
        return t_fault'(1 + (r - 40) % 5);
    endfunction

    // Offer one header word, idling first at random; hold it until taken.
    // Valid stays high from beat to beat unless a gap drops it.
    task automatic send_word(input logic [ihrc_pkg::WORD_W-1:0] w, input logic sof);
        int gap;
        gap = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hdr_ch.valid           <= 1'b1;
        hdr_ch.header_word     <= w;
        hdr_ch.start_of_header <= sof;
        do @(posedge i_clk); while (!hdr_ch.ready);
        board.note_word(w, sof);
        words_sent++;
    endtask

    // Build a header with random content and a consistent checksum, then
    // plant the requested fault. Occasionally stack a second fault so that
    // the check order gets exercised.
    task automatic send_header(input t_fault fault, input bit marked);
        logic [ihrc_pkg::WORD_W-1:0] hw [ihrc_pkg::HEADER_WORDS];
        logic [3:0]                  ver;
        logic [3:0]                  ihl;
        logic [7:0]                  ttl;
        logic [ihrc_pkg::ADDR_W-1:0] dest;
        logic [ihrc_pkg::SUM_W-1:0]  raw;
        for (int i = 0; i < ihrc_pkg::HEADER_WORDS; i++)
            hw[i] = ihrc_pkg::WORD_W'($urandom);

        ver = ihrc_pkg::VERSION_IPV4;
        if (fault == FAULT_VERSION) begin
            ver = 4'($urandom_range(0, 14));
            if (ver >= ihrc_pkg::VERSION_IPV4)
                ver = ver + 1'b1;
        end
        if (fault == FAULT_HDR_LEN)
            ihl = 4'($urandom_range(0, ihrc_pkg::MIN_IHL - 1));
        else
            ihl = 4'($urandom_range(ihrc_pkg::MIN_IHL, 15));
        ttl = (fault == FAULT_TTL || $urandom_range(0, 7) == 0) ? 8'd0
                                                                : 8'($urandom_range(1, 255));
        if (fault == FAULT_DEST) begin
            do dest = $urandom; while (dest == board.host_addr || dest == board.bcast_addr);
        end else begin
            dest = $urandom_range(0, 1) ? board.host_addr : board.bcast_addr;
        end

        hw[0] = {ver, ihl, hw[0][7:0]};
        hw[4] = {ttl, hw[4][7:0]};
        hw[5] = '0;
        hw[8] = dest[31:16];
        hw[9] = dest[15:0];
        raw   = '0;
        for (int i = 0; i < ihrc_pkg::HEADER_WORDS; i++)
            raw = raw + ihrc_pkg::SUM_W'(hw[i]);
        hw[5] = ~board.fold_sum(raw);
        // flip one checksum bit to break the sum
        if (fault == FAULT_CHECKSUM || $urandom_range(0, 7) == 0)
            hw[5] = hw[5] ^ (ihrc_pkg::WORD_W'(1) << $urandom_range(0, ihrc_pkg::WORD_W - 1));

        for (int i = 0; i < ihrc_pkg::HEADER_WORDS; i++)
            send_word(hw[i], (i == 0) && marked);
    endtask

    // Stray words with sparse start marks: partial and abandoned headers
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) send_word(ihrc_pkg::WORD_W'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic run_directed();
        // open a header with a start mark on all-ones words, then abandon it
        for (int i = 0; i < 4; i++)
            send_word('1, i == 0);
        // restart mid-header: all-zero header, version check fails first
        for (int i = 0; i < ihrc_pkg::HEADER_WORDS; i++)
            send_word('0, i == 0);
        // unmarked header with no planted fault right after the verdict
        send_header(FAULT_NONE, 1'b0);
    endtask

    // Mostly well-formed headers, some noise. Mark word zero whenever the
    // word position is off, else mark at random so unmarked back-to-back
    // headers occur. Close with a marked header to leave the block aligned.
    task automatic run_random_traffic(input int quota);
        int stop_at;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_header(pick_fault(),
                            board.word_pos != ihrc_pkg::FIRST_POS ||
                            $urandom_range(0, 1) == 1);
        end
        send_header(pick_fault(), 1'b1);
    endtask

    // Drop valid, wait for every expected verdict, then let the pipe settle
    task automatic wait_for_idle();
        hdr_ch.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both address registers as two back-to-back beats
    task automatic write_addresses(input logic [ihrc_pkg::ADDR_W-1:0] host,
                                   input logic [ihrc_pkg::ADDR_W-1:0] bcast);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= ihrc_pkg::CFG_LOCAL_ADDR;
        cfg_ch.data  <= host;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_register(ihrc_pkg::CFG_LOCAL_ADDR, host);
        cfg_ch.index <= ihrc_pkg::CFG_BCAST_ADDR;
        cfg_ch.data  <= bcast;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_register(ihrc_pkg::CFG_BCAST_ADDR, bcast);
        cfg_ch.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Result side: check each accepted beat, then decide ready for the next
    // cycle. A hold-off request parks ready low until its countdown runs out, so
    // the block fills up and backs up into the header channel.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready)
                board.check_verdict(res_ch.verdict, res_ch.accepted);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                stall_left = pick_gap() - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up when no beat moves on any channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("ipv4_header_receive_check regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [ihrc_pkg::ADDR_W-1:0] shared_addr;
        hdr_ch.valid           <= 1'b0;
        hdr_ch.header_word     <= '0;
        hdr_ch.start_of_header <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= ihrc_pkg::CFG_LOCAL_ADDR;
        cfg_ch.data            <= '0;
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        hold_req      = 1'b0;
        words_sent    = 0;
        cfg_writes    = 0;

        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First phase runs on the reset addresses
        run_directed();
        run_random_traffic(PHASE_WORDS);
        wait_for_idle();

        for (int phase = 1; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    // extremes, no idling on either side
                    write_addresses('0, '1);
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                2: begin
                    // swapped extremes, plus one long hold-off on the result side
                    write_addresses('1, '0);
                    src_idle_pct  = 10;
                    sink_idle_pct = 30;
                    hold_req      = 1'b1;
                end
                3: begin
                    write_addresses($urandom, $urandom);
                    src_idle_pct  = 40;
                    sink_idle_pct = 10;
                end
                default: begin
                    // host and broadcast alias the same address
                    shared_addr = $urandom;
                    write_addresses(shared_addr, shared_addr);
                    src_idle_pct  = 15;
                    sink_idle_pct = 15;
                end
            endcase
            run_random_traffic(PHASE_WORDS);
            wait_for_idle();
        end

        $display("Covered %0d header words and %0d register writes over %0d address settings.",
                 board.words_seen, cfg_writes, NUM_PHASES);
        $display("Verdicts checked: ok %0d, version %0d, hdr len %0d, ttl %0d, dest %0d, csum %0d.",
                 board.verdict_hits[0], board.verdict_hits[1], board.verdict_hits[2],
                 board.verdict_hits[3], board.verdict_hits[4], board.verdict_hits[5]);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
            $display("ipv4_header_receive_check regression: pass");
        else
            $display("ipv4_header_receive_check regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ihrc_pkg.sv
rtl/ihrc_ifs.sv
rtl/ihrc_verdict.sv
rtl/ipv4_header_receive_check.sv
tb/testbench.sv
